// ----- src/lcdbs_pkg.sv -----
// Shared types and constants for the character-LCD bus sequencer.
// No dependencies; imported by the top, front end, queue and back end (not the checker).
`timescale 1ns / 1ps

package lcdbs_pkg;

    // Request classes, settled at acceptance from op and bus_mode
    typedef enum logic [1:0] {
        KIND_BYTE8,
        KIND_BYTE4,
        KIND_INIT8,
        KIND_INIT4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       rs;
    } cmd_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus;
        logic [5:0] wait_before;
        logic [4:0] wait_after;
        logic       last;
    } strobe_t;

    // One entry handed from the front to the queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_xfer_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_INIT  = 1'b1;

    localparam logic MODE_FOUR  = 1'b0;
    localparam logic MODE_EIGHT = 1'b1;

    localparam int STEP_W = 4;  // longest run is 14 strobes

    localparam logic [4:0] WAIT_BYTE  = 5'd10;
    localparam logic [4:0] WAIT_FINAL = 5'd20;

endpackage

// ----- src/char_lcd_bus_sequencer.sv -----
// Character-LCD bus sequencer: front end, command queue and strobe generator.
// Depends on lcdbs_pkg, lcdbs_front, lcdbs_queue, lcdbs_back.
//
// Usage:
//   Requests: a transaction is taken at a clock edge with start high and busy
//   low. op = 0 writes data_byte with register_select as RS; op = 1 plays the
//   power-up command list (data_byte and register_select ignored).
//   Config: cfg_we writes cfg_data into bus_mode (0 four-bit, 1 eight-bit);
//   write only while no request is in flight. The mode is sampled per request.
//   Results: one enable strobe per cycle while strobe is high, with rs_level,
//   bus_value, wait_before_ms, wait_after_ms and last (final strobe of the
//   request). The receiver cannot stall; each result is valid one cycle.
//   Path: an accepted request passes the front holding register, the queue,
//   the current-command register and the output register. Strobes: one per
//   cycle, 1 per eight-bit byte, 2 per four-bit byte, 8 or 14 per init.
//   A two-entry queue plus the front holding register absorb requests; busy
//   rises only when both are full.
//   Reset: bus_mode returns to four-bit, the queue empties, no strobe is shown.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       start,
    output logic       busy,
    input  logic       op,
    input  logic [7:0] data_byte,
    input  logic       register_select,
    output logic       strobe,
    output logic       rs_level,
    output logic [7:0] bus_value,
    output logic [5:0] wait_before_ms,
    output logic [4:0] wait_after_ms,
    output logic       last
);
    import lcdbs_pkg::*;

    cmd_xfer_t push;
    logic      q_full;
    logic      q_nonempty;
    logic      q_pop;
    cmd_t      q_head;

    lcdbs_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .start           (start),
        .op              (op),
        .data_byte       (data_byte),
        .register_select (register_select),
        .queue_full      (q_full),
        .busy            (busy),
        .push            (push)
    );

    lcdbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    lcdbs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_nonempty     (q_nonempty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .strobe         (strobe),
        .rs_level       (rs_level),
        .bus_value      (bus_value),
        .wait_before_ms (wait_before_ms),
        .wait_after_ms  (wait_after_ms),
        .last           (last)
    );

endmodule

// ----- src/lcdbs_front.sv -----
// Front end: holds bus_mode, takes start transactions and classifies them.
// Depends on lcdbs_pkg; feeds lcdbs_queue.
`timescale 1ns / 1ps

module lcdbs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  logic                start,
    input  logic                op,
    input  logic [7:0]          data_byte,
    input  logic                register_select,
    input  logic                queue_full,
    output logic                busy,
    output lcdbs_pkg::cmd_xfer_t push
);
    import lcdbs_pkg::*;

    logic bus_mode_reg;
    logic bus_mode_next;
    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    logic accept;
    logic pushed;

    assign busy   = hold_valid_reg && queue_full;
    assign accept = start && !busy;
    assign pushed = hold_valid_reg && !queue_full;

    assign push.valid = hold_valid_reg;
    assign push.cmd   = hold_cmd_reg;

    always_comb
    begin
        bus_mode_next   = cfg_we ? cfg_data : bus_mode_reg;
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (pushed)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next    = 1'b1;
            hold_cmd_next.data = data_byte;
            hold_cmd_next.rs   = register_select;
            unique case ({op, bus_mode_reg})
                {OP_WRITE, MODE_FOUR}:  hold_cmd_next.kind = KIND_BYTE4;
                {OP_WRITE, MODE_EIGHT}: hold_cmd_next.kind = KIND_BYTE8;
                {OP_INIT, MODE_FOUR}:   hold_cmd_next.kind = KIND_INIT4;
                default:                hold_cmd_next.kind = KIND_INIT8;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg   <= MODE_FOUR;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            bus_mode_reg   <= bus_mode_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

// ----- src/lcdbs_queue.sv -----
// Two-entry command queue between the front end and the strobe generator.
// Depends on lcdbs_pkg.
`timescale 1ns / 1ps

module lcdbs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcdbs_pkg::cmd_xfer_t push,
    input  logic                 pop,
    output logic                 full,
    output logic                 nonempty,
    output lcdbs_pkg::cmd_t      head
);
    import lcdbs_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign head     = mem[rd_ptr_reg];
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ----- src/lcdbs_back.sv -----
// Back end: steps through the strobes of one command, one strobe per cycle, and
// registers the result ports. Depends on lcdbs_pkg; fed by lcdbs_queue.
`timescale 1ns / 1ps

module lcdbs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_nonempty,
    input  lcdbs_pkg::cmd_t q_head,
    output logic            q_pop,
    output logic            strobe,
    output logic            rs_level,
    output logic [7:0]      bus_value,
    output logic [5:0]      wait_before_ms,
    output logic [4:0]      wait_after_ms,
    output logic            last
);
    import lcdbs_pkg::*;

    function automatic strobe_t mk(input logic [7:0] bus, input logic [5:0] wb,
                                   input logic [4:0] wa, input logic lst);
        strobe_t s;
        s.rs          = 1'b0;
        s.bus         = bus;
        s.wait_before = wb;
        s.wait_after  = wa;
        s.last        = lst;
        return s;
    endfunction

    function automatic strobe_t gen_strobe(input cmd_t c, input logic [STEP_W-1:0] step);
        strobe_t s;
        s = mk(8'h00, 6'd0, 5'd0, 1'b0);
        unique case (c.kind)
            KIND_BYTE8:
            begin
                s    = mk(c.data, 6'd0, WAIT_BYTE, 1'b1);
                s.rs = c.rs;
            end
            KIND_BYTE4:
            begin
                if (step[0] == 1'b0)
                begin
                    s = mk({c.data[7:4], 4'h0}, 6'd0, 5'd0, 1'b0);
                end
                else
                begin
                    s = mk({c.data[3:0], 4'h0}, 6'd0, WAIT_BYTE, 1'b1);
                end
                s.rs = c.rs;
            end
            KIND_INIT8:
            begin
                case (step)
                    4'd0:    s = mk(8'h30, 6'd50, WAIT_BYTE, 1'b0);
                    4'd1:    s = mk(8'h30, 6'd5, WAIT_BYTE, 1'b0);
                    4'd2:    s = mk(8'h30, 6'd1, WAIT_BYTE, 1'b0);
                    4'd3:    s = mk(8'h38, 6'd1, WAIT_BYTE, 1'b0);
                    4'd4:    s = mk(8'h08, 6'd1, WAIT_BYTE, 1'b0);
                    4'd5:    s = mk(8'h01, 6'd1, WAIT_BYTE, 1'b0);
                    4'd6:    s = mk(8'h06, 6'd1, WAIT_BYTE, 1'b0);
                    default: s = mk(8'h0C, 6'd1, WAIT_FINAL, 1'b1);
                endcase
            end
            default:
            begin
                // four-bit init: four single nibbles, then five split commands
                case (step)
                    4'd0:    s = mk(8'h30, 6'd50, 5'd0, 1'b0);
                    4'd1:    s = mk(8'h30, 6'd5, 5'd0, 1'b0);
                    4'd2:    s = mk(8'h30, 6'd1, 5'd0, 1'b0);
                    4'd3:    s = mk(8'h20, 6'd1, 5'd0, 1'b0);
                    4'd4:    s = mk(8'h20, 6'd1, 5'd0, 1'b0);
                    4'd5:    s = mk(8'h80, 6'd0, WAIT_BYTE, 1'b0);
                    4'd6:    s = mk(8'h00, 6'd1, 5'd0, 1'b0);
                    4'd7:    s = mk(8'h80, 6'd0, WAIT_BYTE, 1'b0);
                    4'd8:    s = mk(8'h00, 6'd1, 5'd0, 1'b0);
                    4'd9:    s = mk(8'h10, 6'd0, WAIT_BYTE, 1'b0);
                    4'd10:   s = mk(8'h00, 6'd1, 5'd0, 1'b0);
                    4'd11:   s = mk(8'h60, 6'd0, WAIT_BYTE, 1'b0);
                    4'd12:   s = mk(8'h00, 6'd1, 5'd0, 1'b0);
                    default: s = mk(8'hC0, 6'd0, WAIT_FINAL, 1'b1);
                endcase
            end
        endcase
        return s;
    endfunction

    logic              cur_valid_reg;
    logic              cur_valid_next;
    cmd_t              cur_reg;
    cmd_t              cur_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              strobe_reg;
    strobe_t           out_reg;
    strobe_t           cur_strobe;

    always_comb
    begin
        cur_strobe     = gen_strobe(cur_reg, step_reg);
        q_pop          = q_nonempty && (!cur_valid_reg || cur_strobe.last);
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        step_next      = step_reg + STEP_W'(1);
        if (!cur_valid_reg || cur_strobe.last)
        begin
            cur_valid_next = q_nonempty;
            cur_next       = q_head;
            step_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            strobe_reg    <= cur_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= cur_strobe;
    end

    assign strobe         = strobe_reg;
    assign rs_level       = out_reg.rs;
    assign bus_value      = out_reg.bus;
    assign wait_before_ms = out_reg.wait_before;
    assign wait_after_ms  = out_reg.wait_after;
    assign last           = out_reg.last;

endmodule

// ----- src/lcdbs_checker.sv -----
// Port-level checks for char_lcd_bus_sequencer, attached by bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module lcdbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic       rs_level,
    input logic [5:0] wait_before_ms,
    input logic [4:0] wait_after_ms,
    input logic       last
);

    // strobes of one transaction come out back to back
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("strobe run broken before last");

    // only init strobes carry a leading wait, and init always uses RS low
    a_init_rs: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && wait_before_ms != 6'd0 |-> !rs_level)
        else $error("leading wait with RS high");

    // the closing pause only appears on the final strobe
    a_final_pause: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && wait_after_ms == 5'd20 |-> last)
        else $error("closing pause on a non-final strobe");

    // the power-up wait opens an init run that is never one strobe long
    a_powerup: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && wait_before_ms == 6'd50 |-> !last)
        else $error("power-up strobe marked last");

endmodule

bind char_lcd_bus_sequencer lcdbs_checker u_lcdbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .strobe         (strobe),
    .rs_level       (rs_level),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
);

// ----- bench/char_lcd_bus_sequencer_test.sv -----
// Self-checking bench for char_lcd_bus_sequencer: byte writes and power-up
// sequences in both bus modes, predicted strobe by strobe. Needs lcdbs_pkg and the RTL.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_test;
    import lcdbs_pkg::*;

    localparam int CLK_HALF_NS  = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [5:0] WAIT_POWER_UP = 6'd50;
    localparam logic [5:0] WAIT_SECOND   = 6'd5;
    localparam logic [5:0] WAIT_SHORT    = 6'd1;
    localparam logic [5:0] WAIT_NONE     = 6'd0;
    localparam logic [4:0] AFTER_NONE    = 5'd0;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_data;
    logic       start;
    logic       busy;
    logic       op;
    logic [7:0] data_byte;
    logic       register_select;
    logic       strobe;
    logic       rs_level;
    logic [7:0] bus_value;
    logic [5:0] wait_before_ms;
    logic [4:0] wait_after_ms;
    logic       last;

    char_lcd_bus_sequencer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .data_byte       (data_byte),
        .register_select (register_select),
        .strobe          (strobe),
        .rs_level        (rs_level),
        .bus_value       (bus_value),
        .wait_before_ms  (wait_before_ms),
        .wait_after_ms   (wait_after_ms),
        .last            (last)
    );

    class lcd_strobe_scoreboard;
        logic     bus_mode;
        strobe_t  expected_strobes[$];
        int       errors;
        int       reported;

        function new();
            bus_mode = MODE_FOUR;
            errors   = 0;
            reported = 0;
        endfunction

        function logic [5:0] startup_wait(int step);
            if (step == 0)
                return WAIT_POWER_UP;
            else if (step == 1)
                return WAIT_SECOND;
            return WAIT_SHORT;
        endfunction

        function void push_strobe(logic rs, logic [7:0] bus, logic [5:0] wb, logic [4:0] wa);
            strobe_t s;
            s.rs          = rs;
            s.bus         = bus;
            s.wait_before = wb;
            s.wait_after  = wa;
            s.last        = 1'b0;
            expected_strobes.push_back(s);
        endfunction

        // One byte becomes one strobe, or high then low nibble on D7..D4
        function void push_byte(logic rs, logic [7:0] b, logic [5:0] wb, logic [4:0] wa);
            if (bus_mode == MODE_EIGHT)
            begin
                push_strobe(rs, b, wb, wa);
            end
            else
            begin
                push_strobe(rs, {b[7:4], 4'h0}, wb, AFTER_NONE);
                push_strobe(rs, {b[3:0], 4'h0}, WAIT_NONE, wa);
            end
        endfunction

        function void note_request(logic op_i, logic [7:0] data_i, logic rs_i);
            logic [7:0] cmds8 [8];
            logic [3:0] wake4 [4];
            logic [7:0] cmds4 [5];
            int         tail;
            cmds8 = '{8'h30, 8'h30, 8'h30, 8'h38, 8'h08, 8'h01, 8'h06, 8'h0C};
            wake4 = '{4'h3, 4'h3, 4'h3, 4'h2};
            cmds4 = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
            if (op_i == OP_WRITE)
            begin
                push_byte(rs_i, data_i, WAIT_NONE, WAIT_BYTE);
            end
            else if (bus_mode == MODE_EIGHT)
            begin
                for (int i = 0; i < 8; i++)
                    push_byte(1'b0, cmds8[i], startup_wait(i), WAIT_BYTE);
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                    push_strobe(1'b0, {wake4[i], 4'h0}, startup_wait(i), AFTER_NONE);
                for (int i = 0; i < 5; i++)
                    push_byte(1'b0, cmds4[i], startup_wait(4 + i), WAIT_BYTE);
            end
            tail = expected_strobes.size() - 1;
            if (op_i == OP_INIT)
                expected_strobes[tail].wait_after = WAIT_FINAL;
            expected_strobes[tail].last = 1'b1;
        endfunction

        function void flag(string what);
            errors++;
            if (reported < MAX_REPORTS)
            begin
                reported++;
                $display("[%0t] ERROR: %s", $realtime, what);
            end
        endfunction

        function void check_strobe(strobe_t got);
            strobe_t want;
            if (expected_strobes.size() == 0)
            begin
                flag($sformatf("unexpected strobe rs=%0b bus=%02h wb=%0d wa=%0d last=%0b",
                     got.rs, got.bus, got.wait_before, got.wait_after, got.last));
                return;
            end
            want = expected_strobes.pop_front();
            if (got.rs !== want.rs || got.bus !== want.bus
                || got.wait_before !== want.wait_before
                || got.wait_after !== want.wait_after || got.last !== want.last)
                flag($sformatf({"strobe exp rs=%0b bus=%02h wb=%0d wa=%0d last=%0b",
                                " got rs=%0b bus=%02h wb=%0d wa=%0d last=%0b"},
                     want.rs, want.bus, want.wait_before, want.wait_after, want.last,
                     got.rs, got.bus, got.wait_before, got.wait_after, got.last));
        endfunction

        function int pending();
            return expected_strobes.size();
        endfunction
    endclass

    lcd_strobe_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Results cannot be held off; every strobe cycle is one transaction
    always @(posedge clk)
    begin
        strobe_t seen;
        if (rst_n && strobe === 1'b1)
        begin
            seen.rs          = rs_level;
            seen.bus         = bus_value;
            seen.wait_before = wait_before_ms;
            seen.wait_after  = wait_after_ms;
            seen.last        = last;
            sb.check_strobe(seen);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic op_i, input logic [7:0] data_i, input logic rs_i);
        start           <= 1'b1;
        op              <= op_i;
        data_byte       <= data_i;
        register_select <= rs_i;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_request(op_i, data_i, rs_i);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Block must be idle; mode is taken per request
    task automatic write_mode(input logic mode);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        sb.bus_mode = mode;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_data <= ~mode;
    endtask

    task automatic directed_run(input logic mode);
        write_mode(mode);
        send_request(OP_WRITE, 8'h00, 1'b0);
        send_request(OP_WRITE, 8'hFF, 1'b1);
        send_request(OP_WRITE, 8'hA5, 1'b0);
        pause_sender(2);
        send_request(OP_WRITE, 8'h5A, 1'b1);
        send_request(OP_INIT, 8'hFF, 1'b1);    // fields must be ignored
        send_request(OP_WRITE, 8'h0F, 1'b1);
        pause_sender(1);
        send_request(OP_INIT, 8'h00, 1'b0);
        send_request(OP_WRITE, 8'hF0, 1'b0);
        pause_sender(3);
    endtask

    task automatic random_phase(input logic mode, input int count);
        int         sent;
        int         burst;
        logic       op_r;
        logic [7:0] byte_r;
        sent = 0;
        write_mode(mode);
        while (sent < count)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                op_r = ($urandom_range(0, 99) < 15) ? OP_INIT : OP_WRITE;
                case ($urandom_range(0, 9))
                    0:       byte_r = 8'h00;
                    1:       byte_r = 8'hFF;
                    default: byte_r = 8'($urandom_range(0, 255));
                endcase
                send_request(op_r, byte_r, 1'($urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        pause_sender(1);
    endtask

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = 1'b0;
        start           = 1'b0;
        op              = OP_WRITE;
        data_byte       = 8'h00;
        register_select = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset value is four-bit; one request before any write
        send_request(OP_WRITE, 8'hC3, 1'b1);
        pause_sender(2);
        directed_run(MODE_FOUR);
        directed_run(MODE_EIGHT);

        random_phase(MODE_FOUR, 25);
        random_phase(MODE_EIGHT, 25);
        random_phase(1'($urandom_range(0, 1)), 25);
        random_phase(1'($urandom_range(0, 1)), 25);

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
